/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is held.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition at one edge implies a property at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/lsf_pkg.sv */
package lsf_pkg;

  localparam int FRAC_BITS = 14;

  localparam int XI_W   = 16;
  localparam int VAL_W  = 16;
  localparam int SLP_W  = 18;
  localparam int ORD_W  = 2;
  localparam int NODE_W = 2;

  // a = 3x+S, b = 3x-S, p = x+S, m = x-S
  localparam int OP_W = FRAC_BITS + 4;
  localparam int XX_W = 2 * XI_W;

  localparam int QDEPTH = 2;

  typedef enum logic [ORD_W-1:0] {
    ORD_CONST  = 2'd0,
    ORD_LINEAR = 2'd1,
    ORD_QUAD   = 2'd2,
    ORD_CUBIC  = 2'd3
  } lsf_order_t;

  typedef struct packed {
    lsf_order_t             order;
    logic signed [XI_W-1:0] x;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
    logic signed [OP_W-1:0] p;
    logic signed [OP_W-1:0] m;
    logic signed [XX_W-1:0] xx;
  } lsf_item_t;

endpackage

/* design/lsf_front.sv */
`include "assert_macros.svh"

module lsf_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic signed [lsf_pkg::XI_W-1:0]         in_xi,
  output logic                                    in_stall,
  input  logic                                    cfg_wr_en,
  input  logic        [lsf_pkg::ORD_W-1:0]        cfg_wr_data,
  input  logic                                    q_full,
  output logic                                    q_push,
  output lsf_pkg::lsf_item_t                      q_item
);

  localparam int XI_W = lsf_pkg::XI_W;
  localparam int OP_W = lsf_pkg::OP_W;
  localparam int XX_W = lsf_pkg::XX_W;
  localparam logic signed [XI_W-1:0] X_MAX = XI_W'(1 << lsf_pkg::FRAC_BITS);
  localparam logic signed [XI_W-1:0] X_MIN = -X_MAX;
  localparam logic signed [OP_W-1:0] S_OP  = OP_W'(1 << lsf_pkg::FRAC_BITS);

  lsf_pkg::lsf_order_t     order_r;
  logic                    fr_valid_r;
  lsf_pkg::lsf_item_t      fr_item_r;
  lsf_pkg::lsf_item_t      fr_item_nxt;
  logic signed [XI_W-1:0]  xc;
  logic signed [OP_W-1:0]  xe;
  logic                    load;

  assign in_stall = fr_valid_r && q_full;
  assign load     = in_valid && !in_stall;
  assign q_push   = fr_valid_r && !q_full;
  assign q_item   = fr_item_r;

  always_comb begin
    if (in_xi > X_MAX) begin
      xc = X_MAX;
    end else if (in_xi < X_MIN) begin
      xc = X_MIN;
    end else begin
      xc = in_xi;
    end
    xe = OP_W'(xc);
    fr_item_nxt.order = order_r;
    fr_item_nxt.x     = xc;
    fr_item_nxt.a     = xe + (xe <<< 1) + S_OP;
    fr_item_nxt.b     = xe + (xe <<< 1) - S_OP;
    fr_item_nxt.p     = xe + S_OP;
    fr_item_nxt.m     = xe - S_OP;
    fr_item_nxt.xx    = XX_W'(xc) * XX_W'(xc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r    <= lsf_pkg::ORD_LINEAR;
      fr_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        order_r <= lsf_pkg::lsf_order_t'(cfg_wr_data);
      end
      if (load) begin
        fr_valid_r <= 1'b1;
      end else if (q_push) begin
        fr_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fr_item_r <= fr_item_nxt;
    end
  end

  `ASSERT_NEXT(a_front_hold, clk, rst_n, fr_valid_r && q_full, $stable(fr_item_r), "front item changed while queue full")

endmodule

/* design/lsf_queue.sv */
`include "assert_macros.svh"

module lsf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lsf_pkg::lsf_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output lsf_pkg::lsf_item_t head_item
);

  localparam int DEPTH = lsf_pkg::QDEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  lsf_pkg::lsf_item_t mem_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r;
  logic [AW-1:0]      rd_ptr_r;
  logic [CW-1:0]      count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_CLKRST(a_q_no_overflow, clk, rst_n, push |-> !full, "push into full queue")
  `ASSERT_CLKRST(a_q_no_underflow, clk, rst_n, pop |-> head_valid, "pop from empty queue")
  `ASSERT_CLKRST(a_q_count, clk, rst_n, count_r <= CW'(DEPTH), "queue count beyond depth")

endmodule

/* design/lsf_back.sv */
`include "assert_macros.svh"

module lsf_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               head_valid,
  input  lsf_pkg::lsf_item_t                 head_item,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [lsf_pkg::NODE_W-1:0]  out_node_index,
  output logic signed [lsf_pkg::VAL_W-1:0]   out_basis_value,
  output logic signed [lsf_pkg::SLP_W-1:0]   out_basis_slope,
  output logic                               out_last
);

  localparam int F      = lsf_pkg::FRAC_BITS;
  localparam int OP_W   = lsf_pkg::OP_W;
  localparam int NODE_W = lsf_pkg::NODE_W;
  localparam int VAL_W  = lsf_pkg::VAL_W;
  localparam int SLP_W  = lsf_pkg::SLP_W;
  localparam int M1_W   = 2 * OP_W + 1;
  localparam int R1_W   = F + 6;
  localparam int M2_W   = R1_W + OP_W + 1;
  localparam int R2_W   = F + 8;
  localparam int SC_W   = R2_W + 4;
  localparam int SN_W   = 2 * F + 10;

  localparam logic signed [OP_W-1:0] S_OP    = OP_W'(1 << F);
  localparam logic signed [OP_W-1:0] HALF_OP = OP_W'(1 << (F - 1));
  localparam logic signed [M1_W-1:0] H1_LO   = M1_W'(1) <<< (F - 1);
  localparam logic signed [M1_W-1:0] H1_HI   = M1_W'(1) <<< F;
  localparam logic signed [M2_W-1:0] H2      = M2_W'(1) <<< (F - 1);
  localparam logic signed [SN_W-1:0] SN_HALF = SN_W'(1 << (F - 1));
  localparam logic signed [SN_W-1:0] SN_RND  = SN_W'(1) <<< (F + 3);
  localparam logic signed [SN_W-1:0] C0_1    = SN_W'(1 << (F - 4));
  localparam logic signed [SN_W-1:0] C0_27   = SN_W'(27 * (1 << (F - 4)));
  localparam logic signed [SC_W-1:0] VAL_RND = SC_W'(8);
  localparam logic signed [SC_W-1:0] VAL_HI  = SC_W'((1 << (VAL_W - 1)) - 1);
  localparam logic signed [SC_W-1:0] VAL_LO  = -VAL_HI - SC_W'(1);
  localparam logic signed [SN_W-1:0] SLP_HI  = SN_W'((1 << (SLP_W - 1)) - 1);
  localparam logic signed [SN_W-1:0] SLP_LO  = -SLP_HI - SN_W'(1);

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SC_W-1:0] t);
    logic signed [SC_W-1:0] c;
    if (t > VAL_HI) begin
      c = VAL_HI;
    end else if (t < VAL_LO) begin
      c = VAL_LO;
    end else begin
      c = t;
    end
    return VAL_W'(c);
  endfunction

  function automatic logic signed [SLP_W-1:0] sat_slp(input logic signed [SN_W-1:0] t);
    logic signed [SN_W-1:0] c;
    if (t > SLP_HI) begin
      c = SLP_HI;
    end else if (t < SLP_LO) begin
      c = SLP_LO;
    end else begin
      c = t;
    end
    return SLP_W'(c);
  endfunction

  // node sequencer
  logic [NODE_W-1:0] node_r;
  logic              en;
  logic              issue;
  logic              is_last;
  logic              cubic;

  // stage 1
  logic signed [OP_W-1:0]   u, v, w;
  logic                     wide;
  logic signed [SN_W-1:0]   sn;
  logic signed [SN_W-1:0]   xe, xxe, xx27, xx81, xs18;
  logic signed [2*OP_W-1:0] prod1;
  logic signed [M1_W-1:0]   mul1_nxt;

  logic                     s1_valid_r;
  logic signed [M1_W-1:0]   s1_mul_r;
  logic                     s1_wide_r;
  logic signed [OP_W-1:0]   s1_w_r;
  logic signed [SN_W-1:0]   s1_sn_r;
  logic                     s1_cubic_r;
  logic [NODE_W-1:0]        s1_node_r;
  logic                     s1_last_r;

  // stage 2
  logic signed [R1_W-1:0]      r1;
  logic signed [R1_W+OP_W-1:0] prod2;
  logic signed [M2_W-1:0]      mul2_nxt;
  logic signed [SN_W-1:0]      sr;
  logic signed [SN_W-1:0]      c0;
  logic signed [SLP_W-1:0]     slope_nxt;

  logic                     s2_valid_r;
  logic signed [M2_W-1:0]   s2_mul_r;
  logic signed [SLP_W-1:0]  s2_slope_r;
  logic                     s2_cubic_r;
  logic [NODE_W-1:0]        s2_node_r;
  logic                     s2_last_r;

  // stage 3
  logic signed [R2_W-1:0]   r2;
  logic signed [SC_W-1:0]   r2e;
  logic signed [SC_W-1:0]   t;
  logic signed [VAL_W-1:0]  val_nxt;

  logic                     out_valid_r;
  logic [NODE_W-1:0]        out_node_index_r;
  logic signed [VAL_W-1:0]  out_basis_value_r;
  logic signed [SLP_W-1:0]  out_basis_slope_r;
  logic                     out_last_r;

  assign en      = !out_valid_r || !out_stall;
  assign issue   = en && head_valid;
  assign is_last = (node_r == NODE_W'(head_item.order));
  assign pop     = issue && is_last;
  assign cubic   = (head_item.order == lsf_pkg::ORD_CUBIC);

  assign xe   = SN_W'(head_item.x);
  assign xxe  = SN_W'(head_item.xx);
  assign xx27 = (xxe <<< 5) - (xxe <<< 2) - xxe;
  assign xx81 = (xxe <<< 6) + (xxe <<< 4) + xxe;
  assign xs18 = ((xe <<< 4) + (xe <<< 1)) <<< F;

  always_comb begin
    u    = S_OP;
    v    = S_OP;
    w    = S_OP;
    wide = 1'b0;
    sn   = '0;
    case (head_item.order)
      lsf_pkg::ORD_CONST: begin
        sn = '0;
      end
      lsf_pkg::ORD_LINEAR: begin
        v = HALF_OP;
        if (node_r == NODE_W'(0)) begin
          u  = -head_item.m;
          sn = -SN_HALF;
        end else begin
          u  = head_item.p;
          sn = SN_HALF;
        end
      end
      lsf_pkg::ORD_QUAD: begin
        case (node_r)
          NODE_W'(0): begin
            u    = head_item.x;
            v    = head_item.m;
            wide = 1'b1;
            sn   = xe - SN_HALF;
          end
          NODE_W'(1): begin
            u  = -head_item.p;
            v  = head_item.m;
            sn = -(xe <<< 1);
          end
          default: begin
            u    = head_item.x;
            v    = head_item.p;
            wide = 1'b1;
            sn   = xe + SN_HALF;
          end
        endcase
      end
      lsf_pkg::ORD_CUBIC: begin
        case (node_r)
          NODE_W'(0): begin
            u  = head_item.a;
            v  = head_item.b;
            w  = head_item.m;
            sn = xs18 - xx27;
          end
          NODE_W'(1): begin
            u  = head_item.p;
            v  = head_item.b;
            w  = head_item.m;
            sn = xx81 - xs18;
          end
          NODE_W'(2): begin
            u  = head_item.p;
            v  = head_item.a;
            w  = head_item.m;
            sn = -xx81 - xs18;
          end
          default: begin
            u  = head_item.p;
            v  = head_item.a;
            w  = head_item.b;
            sn = xx27 + xs18;
          end
        endcase
      end
      default: begin
        sn = '0;
      end
    endcase
  end

  assign prod1    = u * v;
  assign mul1_nxt = M1_W'(prod1) + (wide ? H1_HI : H1_LO);

  assign r1       = s1_wide_r ? R1_W'(s1_mul_r >>> (F + 1)) : R1_W'(s1_mul_r >>> F);
  assign prod2    = r1 * s1_w_r;
  assign mul2_nxt = M2_W'(prod2) + H2;
  assign sr       = (s1_sn_r + SN_RND) >>> (F + 4);

  always_comb begin
    case (s1_node_r)
      NODE_W'(0): c0 = C0_1;
      NODE_W'(1): c0 = -C0_27;
      NODE_W'(2): c0 = C0_27;
      default:    c0 = -C0_1;
    endcase
    slope_nxt = s1_cubic_r ? sat_slp(sr + c0) : sat_slp(s1_sn_r);
  end

  assign r2  = R2_W'(s2_mul_r >>> F);
  assign r2e = SC_W'(r2);

  always_comb begin
    case (s2_node_r)
      NODE_W'(0): t = -r2e;
      NODE_W'(1): t = (r2e <<< 3) + r2e;
      NODE_W'(2): t = -((r2e <<< 3) + r2e);
      default:    t = r2e;
    endcase
    val_nxt = s2_cubic_r ? sat_val((t + VAL_RND) >>> 4) : sat_val(r2e);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r      <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        node_r <= is_last ? '0 : node_r + NODE_W'(1);
      end
      if (en) begin
        s1_valid_r  <= issue;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mul_r          <= mul1_nxt;
      s1_wide_r         <= wide;
      s1_w_r            <= w;
      s1_sn_r           <= sn;
      s1_cubic_r        <= cubic;
      s1_node_r         <= node_r;
      s1_last_r         <= is_last;
      s2_mul_r          <= mul2_nxt;
      s2_slope_r        <= slope_nxt;
      s2_cubic_r        <= s1_cubic_r;
      s2_node_r         <= s1_node_r;
      s2_last_r         <= s1_last_r;
      out_node_index_r  <= s2_node_r;
      out_basis_value_r <= val_nxt;
      out_basis_slope_r <= s2_slope_r;
      out_last_r        <= s2_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_node_index_r;
  assign out_basis_value = out_basis_value_r;
  assign out_basis_slope = out_basis_slope_r;
  assign out_last        = out_last_r;

  `ASSERT_CLKRST(a_node_in_range, clk, rst_n, (head_valid || node_r == '0) && (!head_valid || node_r <= NODE_W'(head_item.order)), "node counter outside element")

endmodule

/* design/lagrange_shape_function_eval.sv */
// Channel  Dir  Handshake              Payload                               Transfer when
// in       in   in_valid / in_stall    in_xi                                 in_valid && !in_stall
// out      out  out_valid / out_stall  out_node_index, out_basis_value,      out_valid && !out_stall
//                                      out_basis_slope, out_last
// cfg      in   cfg_wr_en              cfg_wr_data (element order)           cfg_wr_en
//
// One xi gives element_order+1 results, one per cycle while out_stall does not hold the output; the
// node sequencer issues one node a cycle, unless stalled, into the three-stage multiply pipeline.
// The first result passes the front register, the queue and the stage 1, stage 2 and output registers.
// Reset (rst_n low at a rising edge) empties front, queue and pipeline; order returns to linear.
// out_stall, while a result waits at the output, freezes the whole back pipeline; the front register and
// two-entry queue keep taking input until both are full.
module lagrange_shape_function_eval (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [lsf_pkg::XI_W-1:0]    in_xi,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [lsf_pkg::NODE_W-1:0]  out_node_index,
  output logic signed [lsf_pkg::VAL_W-1:0]   out_basis_value,
  output logic signed [lsf_pkg::SLP_W-1:0]   out_basis_slope,
  output logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic        [lsf_pkg::ORD_W-1:0]   cfg_wr_data
);

  logic               q_push;
  lsf_pkg::lsf_item_t q_item;
  logic               q_full;
  logic               q_pop;
  logic               q_head_valid;
  lsf_pkg::lsf_item_t q_head_item;

  lsf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_xi       (in_xi),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  lsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  lsf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_item       (q_head_item),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node_index  (out_node_index),
    .out_basis_value (out_basis_value),
    .out_basis_slope (out_basis_slope),
    .out_last        (out_last)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int     FRAC_BITS = lsf_pkg::FRAC_BITS;
  localparam int     XI_W      = lsf_pkg::XI_W;
  localparam int     VAL_W     = lsf_pkg::VAL_W;
  localparam int     SLP_W     = lsf_pkg::SLP_W;
  localparam int     ORD_W     = lsf_pkg::ORD_W;
  localparam int     NODE_W    = lsf_pkg::NODE_W;
  localparam longint S         = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic        [NODE_W-1:0] node;
    logic signed [VAL_W-1:0]  value;
    logic signed [SLP_W-1:0]  slope;
    logic                     last;
  } node_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [XI_W-1:0]   in_xi;
  logic                     out_valid;
  logic                     out_stall;
  logic        [NODE_W-1:0] out_node_index;
  logic signed [VAL_W-1:0]  out_basis_value;
  logic signed [SLP_W-1:0]  out_basis_slope;
  logic                     out_last;
  logic                     cfg_wr_en;
  logic        [ORD_W-1:0]  cfg_wr_data;

  lsf_pkg::lsf_order_t elem_order = lsf_pkg::ORD_LINEAR;
  node_result_t        node_q [$];
  int                  errors = 0;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  hold_len = 0;

  lagrange_shape_function_eval uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_xi           (in_xi),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node_index  (out_node_index),
    .out_basis_value (out_basis_value),
    .out_basis_slope (out_basis_slope),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // round half up: floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint round_shift(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint cubic_slope(input longint x, input longint c2, input longint c1,
                                         input longint c0);
    return round_shift(c2 * x * x + c1 * x * S, FRAC_BITS + 4) + c0 * (S / 16);
  endfunction

  function automatic void predict_nodes(input logic signed [XI_W-1:0] xi);
    longint       x, a, b, p, m, pa;
    longint       val [4];
    longint       slp [4];
    int           n;
    node_result_t r;
    x = longint'(xi);
    if (x > S) x = S;
    if (x < -S) x = -S;
    case (elem_order)
      lsf_pkg::ORD_CONST: begin
        val[0] = S;
        slp[0] = 0;
        n = 1;
      end
      lsf_pkg::ORD_LINEAR: begin
        val[0] = round_shift(S - x, 1);
        val[1] = round_shift(S + x, 1);
        slp[0] = -(S / 2);
        slp[1] = S / 2;
        n = 2;
      end
      lsf_pkg::ORD_QUAD: begin
        val[0] = round_shift(x * (x - S), FRAC_BITS + 1);
        val[1] = round_shift(S * S - x * x, FRAC_BITS);
        val[2] = round_shift(x * (x + S), FRAC_BITS + 1);
        slp[0] = x - S / 2;
        slp[1] = -2 * x;
        slp[2] = x + S / 2;
        n = 3;
      end
      default: begin
        a = 3 * x + S;
        b = 3 * x - S;
        p = x + S;
        m = x - S;
        pa = round_shift(p * a, FRAC_BITS);
        val[0] = round_shift(-round_shift(round_shift(a * b, FRAC_BITS) * m, FRAC_BITS), 4);
        val[1] = round_shift(9 * round_shift(round_shift(p * b, FRAC_BITS) * m, FRAC_BITS), 4);
        val[2] = round_shift(-9 * round_shift(pa * m, FRAC_BITS), 4);
        val[3] = round_shift(round_shift(pa * b, FRAC_BITS), 4);
        slp[0] = cubic_slope(x, -27, 18, 1);
        slp[1] = cubic_slope(x, 81, -18, -27);
        slp[2] = cubic_slope(x, -81, -18, 27);
        slp[3] = cubic_slope(x, 27, 18, -1);
        n = 4;
      end
    endcase
    for (int k = 0; k < n; k++) begin
      r.node  = k[NODE_W-1:0];
      r.value = VAL_W'(clip(val[k], -32768, 32767));
      r.slope = SLP_W'(clip(slp[k], -131072, 131071));
      r.last  = (k == n - 1);
      node_q.push_back(r);
    end
  endfunction

  // receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    node_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (node_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: node %0d value %0d slope %0d last %0b",
                   out_node_index, out_basis_value, out_basis_slope, out_last);
      end else begin
        want = node_q.pop_front();
        if (out_node_index !== want.node || out_basis_value !== want.value ||
            out_basis_slope !== want.slope || out_last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp node %0d value %0d slope %0d last %0b, ",
                      "got node %0d value %0d slope %0d last %0b"},
                     want.node, want.value, want.slope, want.last,
                     out_node_index, out_basis_value, out_basis_slope, out_last);
        end
      end
    end
  end

  // called and returns at a falling edge; leaves in_valid high unless a gap was taken
  task automatic send_xi(input logic signed [XI_W-1:0] xi);
    in_xi <= xi;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_nodes(xi);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (node_q.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_order(input lsf_pkg::lsf_order_t o);
    drain_results();
    cfg_wr_data <= o;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    elem_order = o;
  endtask

  function automatic logic signed [XI_W-1:0] random_xi();
    int raw;
    if ($urandom_range(9) < 8)
      raw = int'($urandom_range(32'(2 * S))) - int'(S);
    else
      raw = int'($urandom);
    return raw[XI_W-1:0];
  endfunction

  // linear element straight out of reset, incl. clamping and odd-value rounding
  task automatic test_reset_order();
    int pts [7] = '{-32768, 32767, -16384, 16384, 0, 1, -1};
    foreach (pts[i]) send_xi(pts[i][XI_W-1:0]);
    drain_results();
  endtask

  task automatic test_each_order();
    int const_pts [2] = '{-32768, 32767};
    int quad_pts  [6] = '{-16384, 16384, 0, -8192, 1, -1};
    int cubic_pts [8] = '{-16384, 16384, 5461, -5461, 0, -32768, 32767, 12345};
    write_order(lsf_pkg::ORD_CONST);
    foreach (const_pts[i]) send_xi(const_pts[i][XI_W-1:0]);
    write_order(lsf_pkg::ORD_QUAD);
    foreach (quad_pts[i]) send_xi(quad_pts[i][XI_W-1:0]);
    write_order(lsf_pkg::ORD_CUBIC);
    foreach (cubic_pts[i]) send_xi(cubic_pts[i][XI_W-1:0]);
    drain_results();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int run = 0; run < 2; run++) begin
      write_order(lsf_pkg::lsf_order_t'($urandom_range(3)));
      for (int i = 0; i < 18; i++) send_xi(random_xi());
    end
    drain_results();
  endtask

  // receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_order(lsf_pkg::ORD_CUBIC);
    hold_len = 60;
    for (int i = 0; i < 12; i++) send_xi(random_xi());
    drain_results();
    write_order(lsf_pkg::ORD_CONST);
    hold_len = 40;
    for (int i = 0; i < 12; i++) send_xi(random_xi());
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_xi = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = lsf_pkg::ORD_LINEAR;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_order();
    test_each_order();
    test_random_traffic(34, 56);
    test_random_traffic(56, 34);
    test_random_traffic(0, 0);
    test_backpressure();

    while (node_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && node_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
